### hw/rtl/srag_pkg.sv
// ----------------------------------------------------------------------------
// srag_pkg: shared types and constants of the stream register address generator
// The item codes, the register map and the structs passed between the
// register file, the loop walker and the top level are defined here.
// ----------------------------------------------------------------------------
package srag_pkg;

   localparam int NUM_DIMS  = 4;
   localparam int DIM_W     = 2;
   localparam int DATA_W    = 32;
   localparam int CNT_W     = 33;
   localparam int KIND_W    = 2;
   localparam int IDX_W     = 5;
   localparam int PTR_BITS  = 27;

   // Item kinds.
   localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STREAM = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ENABLE = 2'd3;

   // Register map.
   localparam logic [IDX_W-1:0] REG_STATUS      = 5'd0;
   localparam logic [IDX_W-1:0] REG_REP_LIMIT   = 5'd1;
   localparam logic [IDX_W-1:0] REG_BOUND0      = 5'd2;
   localparam logic [IDX_W-1:0] REG_BOUND_LAST  = 5'd5;
   localparam logic [IDX_W-1:0] REG_STRIDE0     = 5'd6;
   localparam logic [IDX_W-1:0] REG_STRIDE_LAST = 5'd9;
   localparam logic [IDX_W-1:0] REG_RPTR0       = 5'd24;
   localparam logic [IDX_W-1:0] REG_WPTR0       = 5'd28;
   localparam logic [IDX_W-1:0] REG_WPTR_LAST   = 5'd31;

   // Stride values that give a naturally aligned access.
   localparam logic [DATA_W-1:0] STRIDE_NARROW = 32'h4;
   localparam logic [DATA_W-1:0] STRIDE_WIDE   = 32'h8;

   // One item as it leaves the input register, with its firing strobe.
   typedef struct packed {
      logic                 fire;
      logic [KIND_W-1:0]    kind;
      logic [IDX_W-1:0]     reg_index;
      logic [DATA_W-1:0]    write_value;
   } cmd_type;

   // Configuration seen by the loop walker.
   typedef struct packed {
      logic [DATA_W-1:0]                 repeat_limit;
      logic [NUM_DIMS-1:0][DATA_W-1:0]   bounds;
      logic [NUM_DIMS-1:0][DATA_W-1:0]   strides;
      logic [DIM_W-1:0]                  dims;
      logic                              ptr_load;
      logic [DATA_W-1:0]                 ptr_value;
   } cfg_type;

   // Per-item outcome of the loop walker.
   typedef struct packed {
      logic [DATA_W-1:0]    stream_addr;
      logic                 wide_access;
      logic                 misaligned;
      logic                 repeat_wrapped;
      logic                 done_next;
      logic                 done_now;
   } access_type;

endpackage

### hw/rtl/srag_csr_file.sv
// ----------------------------------------------------------------------------
// srag_csr_file: register file of the address generator
// Holds the repeat limit, loop bounds, strides and pointers, decodes writes
// and returns register or status reads.
// ----------------------------------------------------------------------------
module srag_csr_file
   import srag_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic              done_flag,
   output cfg_type           cfg,
   output logic [DATA_W-1:0] read_data
);

   logic [DATA_W-1:0]               repeat_ff, repeat_in;
   logic [NUM_DIMS-1:0][DATA_W-1:0] bounds_ff, bounds_in;
   logic [NUM_DIMS-1:0][DATA_W-1:0] strides_ff, strides_in;
   logic [NUM_DIMS-1:0][DATA_W-1:0] pointers_ff, pointers_in;
   logic [DIM_W-1:0]                dims_ff, dims_in;
   logic                            dir_ff, dir_in;
   logic                            ptr_load;
   logic [DIM_W-1:0]                bound_sel;
   logic [DIM_W-1:0]                stride_sel;
   logic [DIM_W-1:0]                ptr_sel;
   logic [DATA_W-1:0]               cur_ptr;

   assign bound_sel  = DIM_W'(cmd.reg_index - REG_BOUND0);
   assign stride_sel = DIM_W'(cmd.reg_index - REG_STRIDE0);
   assign ptr_sel    = cmd.reg_index[DIM_W-1:0];
   assign cur_ptr    = pointers_ff[dims_ff];

   always_comb begin
      repeat_in   = repeat_ff;
      bounds_in   = bounds_ff;
      strides_in  = strides_ff;
      pointers_in = pointers_ff;
      dims_in     = dims_ff;
      dir_in      = dir_ff;
      ptr_load    = 1'b0;
      if (cmd.fire && cmd.kind == KIND_WRITE) begin
         case (cmd.reg_index) inside
            REG_REP_LIMIT: begin
               repeat_in = cmd.write_value;
            end
            [REG_BOUND0:REG_BOUND_LAST]: begin
               bounds_in[bound_sel] = cmd.write_value;
            end
            [REG_STRIDE0:REG_STRIDE_LAST]: begin
               strides_in[stride_sel] = cmd.write_value;
            end
            [REG_RPTR0:REG_WPTR_LAST]: begin
               pointers_in[ptr_sel] = cmd.write_value;
               dims_in              = ptr_sel;
               dir_in               = (cmd.reg_index >= REG_WPTR0);
               ptr_load             = 1'b1;
            end
            default: begin
               // Status and unused indexes ignore writes.
            end
         endcase
      end
   end

   always_comb begin
      read_data = '0;
      if (cmd.kind == KIND_READ) begin
         case (cmd.reg_index) inside
            REG_STATUS: begin
               read_data = {done_flag, dir_ff, dims_ff, 1'b0, cur_ptr[PTR_BITS-1:0]};
            end
            REG_REP_LIMIT: begin
               read_data = repeat_ff;
            end
            [REG_BOUND0:REG_BOUND_LAST]: begin
               read_data = bounds_ff[bound_sel];
            end
            [REG_STRIDE0:REG_STRIDE_LAST]: begin
               read_data = strides_ff[stride_sel];
            end
            [REG_RPTR0:REG_WPTR_LAST]: begin
               read_data = pointers_ff[ptr_sel];
            end
            default: begin
               read_data = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_ff   <= '0;
         bounds_ff   <= '0;
         strides_ff  <= '0;
         pointers_ff <= '0;
         dims_ff     <= '0;
         dir_ff      <= 1'b0;
      end else begin
         repeat_ff   <= repeat_in;
         bounds_ff   <= bounds_in;
         strides_ff  <= strides_in;
         pointers_ff <= pointers_in;
         dims_ff     <= dims_in;
         dir_ff      <= dir_in;
      end
   end

   assign cfg.repeat_limit = repeat_ff;
   assign cfg.bounds       = bounds_ff;
   assign cfg.strides      = strides_ff;
   assign cfg.dims         = dims_ff;
   assign cfg.ptr_load     = ptr_load;
   assign cfg.ptr_value    = cmd.write_value;

endmodule

### hw/rtl/srag_loop_walker.sv
// ----------------------------------------------------------------------------
// srag_loop_walker: address and nested loop counter logic
// Forms the access address, steps the repeat and loop counters and keeps the
// pending increment and the sticky done flag.
// ----------------------------------------------------------------------------
module srag_loop_walker
   import srag_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  cfg_type    cfg,
   output access_type acc
);

   logic [DATA_W-1:0] cur_ff, cur_in;
   logic [DATA_W-1:0] incr_ff, incr_in;
   logic [CNT_W-1:0]  rep_ff, rep_in;
   logic [CNT_W-1:0]  cnt_ff [NUM_DIMS];
   logic [CNT_W-1:0]  cnt_in [NUM_DIMS];
   logic              done_ff, done_in;

   logic [DATA_W-1:0] addr;
   logic [CNT_W-1:0]  rep_inc;
   logic              rep_wrap;
   logic [CNT_W-1:0]  cnt_inc  [NUM_DIMS];
   logic [CNT_W-1:0]  step_cnt [NUM_DIMS];
   logic              over     [NUM_DIMS];
   logic [NUM_DIMS:0] carry;
   logic [DATA_W-1:0] step_incr;
   logic              done_set;
   logic              is_stream;

   assign addr      = cur_ff + incr_ff;
   assign rep_inc   = rep_ff + CNT_W'(1);
   assign rep_wrap  = rep_inc > {1'b0, cfg.repeat_limit};
   assign is_stream = (cmd.kind == KIND_STREAM);

   // Carry ripples from dimension 0 up to the top dimension in use. A
   // dimension wraps when its count, plus the carry, passes its bound.
   always_comb begin
      carry     = '0;
      carry[0]  = 1'b1;
      step_incr = cfg.strides[0];
      done_set  = 1'b0;
      for (int i = 0; i < NUM_DIMS; i++) begin
         cnt_inc[i]  = cnt_ff[i] + CNT_W'(1);
         over[i]     = carry[i] ? (cnt_inc[i] > {1'b0, cfg.bounds[i]})
                                : (cnt_ff[i] > {1'b0, cfg.bounds[i]});
         step_cnt[i] = cnt_ff[i];
         if (i <= int'(cfg.dims)) begin
            step_cnt[i] = over[i] ? '0 : (carry[i] ? cnt_inc[i] : cnt_ff[i]);
            if (i < int'(cfg.dims)) begin
               carry[i+1] = over[i];
            end else begin
               done_set = over[i];
            end
         end
         if (i > 0 && carry[i]) begin
            step_incr = cfg.strides[i];
         end
      end
   end

   always_comb begin
      cur_in  = cur_ff;
      incr_in = incr_ff;
      rep_in  = rep_ff;
      done_in = done_ff;
      for (int i = 0; i < NUM_DIMS; i++) begin
         cnt_in[i] = cnt_ff[i];
      end
      if (cmd.fire) begin
         case (cmd.kind)
            KIND_STREAM: begin
               cur_in = addr;
               if (rep_wrap) begin
                  rep_in  = '0;
                  incr_in = step_incr;
                  for (int i = 0; i < NUM_DIMS; i++) begin
                     cnt_in[i] = step_cnt[i];
                  end
                  if (done_set) begin
                     done_in = 1'b1;
                  end
               end else begin
                  rep_in  = rep_inc;
                  incr_in = '0;
               end
            end
            KIND_WRITE: begin
               if (cfg.ptr_load) begin
                  cur_in  = cfg.ptr_value;
                  incr_in = '0;
               end
            end
            KIND_ENABLE: begin
               done_in = 1'b0;
            end
            default: begin
               // Reads leave the walker untouched.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff  <= '0;
         incr_ff <= '0;
         rep_ff  <= '0;
         done_ff <= 1'b0;
         for (int i = 0; i < NUM_DIMS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         cur_ff  <= cur_in;
         incr_ff <= incr_in;
         rep_ff  <= rep_in;
         done_ff <= done_in;
         for (int i = 0; i < NUM_DIMS; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   assign acc.stream_addr    = is_stream ? addr : '0;
   assign acc.wide_access    = is_stream && (cfg.strides[0] != STRIDE_NARROW);
   assign acc.misaligned     = is_stream && (cfg.strides[0] != STRIDE_NARROW)
                               && (cfg.strides[0] != STRIDE_WIDE);
   assign acc.repeat_wrapped = is_stream && rep_wrap;
   assign acc.done_next      = done_in;
   assign acc.done_now       = done_ff;

endmodule

### hw/rtl/stream_register_address_generator_top.sv
// ----------------------------------------------------------------------------
// stream_register_address_generator_top: stream register address generator
// Takes register writes, register reads, stream accesses and enables as
// items and returns one result item for each of them.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload
//   req_*     in         tuser: kind; tdata: reg_index, write_value
//   rsp_*     out        tdata: read_data, stream_addr, then the four access flags
//
// One item can be accepted every cycle while results are taken: the register
// file and the loop walker handle the item in the input register in a single
// pass, and the result then waits in the output register behind rsp_tvalid.
// Reset is synchronous and active high and clears all state and counters but the payload registers at once.
// A result that waits holds the output register; req_tready then drops only
// while the input register also holds an item, until the result is taken.
//
module stream_register_address_generator_top
   import srag_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [4:0] reg_index, [36:5] write_value, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] kind
   // Result items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // [31:0] read_data, [63:32] stream_addr,
                                    // [64] wide_access, [65] misaligned,
                                    // [66] repeat_wrapped, [67] stream_done
);

   // Input register.
   logic              in_valid_ff, in_valid_in;
   logic [KIND_W-1:0] in_kind_ff;
   logic [IDX_W-1:0]  in_idx_ff;
   logic [DATA_W-1:0] in_value_ff;

   // Output register.
   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_read_ff;
   logic [DATA_W-1:0] out_addr_ff;
   logic              out_wide_ff;
   logic              out_mis_ff;
   logic              out_wrap_ff;
   logic              out_done_ff;

   logic              fire;
   logic              req_accept;
   cmd_type           cmd;
   cfg_type           cfg;
   access_type        acc;
   logic [DATA_W-1:0] read_data;

   // The item in the input register is handled when the output register is
   // free or is being emptied in this cycle.
   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign req_accept = req_tvalid && req_tready;

   assign in_valid_in  = req_accept || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && !rsp_tready);

   assign cmd.fire        = fire;
   assign cmd.kind        = in_kind_ff;
   assign cmd.reg_index   = in_idx_ff;
   assign cmd.write_value = in_value_ff;

   srag_csr_file u_csr_file (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .done_flag (acc.done_now),
      .cfg       (cfg),
      .read_data (read_data)
   );

   srag_loop_walker u_loop_walker (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .cfg   (cfg),
      .acc   (acc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load only on their handshake and need no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_kind_ff  <= req_tuser;
         in_idx_ff   <= req_tdata[IDX_W-1:0];
         in_value_ff <= req_tdata[IDX_W+DATA_W-1:IDX_W];
      end
      if (fire) begin
         out_read_ff <= read_data;
         out_addr_ff <= acc.stream_addr;
         out_wide_ff <= acc.wide_access;
         out_mis_ff  <= acc.misaligned;
         out_wrap_ff <= acc.repeat_wrapped;
         out_done_ff <= acc.done_next;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_done_ff, out_wrap_ff, out_mis_ff, out_wide_ff,
                        out_addr_ff, out_read_ff};

   // The input side only stalls behind a result that is waiting.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (out_valid_ff && !rsp_tready))
      else $error("input stalled without a waiting result");

   // An enable item leaves the done flag clear.
   assert property (@(posedge clock) disable iff (reset)
      (fire && in_kind_ff == KIND_ENABLE) |=> (!acc.done_now && !out_done_ff))
      else $error("done flag not cleared by enable");

   // A read item produces a result with no access fields set.
   assert property (@(posedge clock) disable iff (reset)
      (fire && in_kind_ff == KIND_READ) |=>
         (rsp_tvalid && out_addr_ff == '0 && !out_wide_ff && !out_wrap_ff))
      else $error("read result carries access fields");

   // A misaligned access is never reported as a narrow one.
   assert property (@(posedge clock) disable iff (reset)
      (fire && acc.misaligned) |=> out_wide_ff)
      else $error("misaligned access marked narrow");

endmodule
